@@ rtl/shfr_pkg.sv @@
// Package for the sync-header frame receiver.
// Holds the header and type constants, the command code type and the result struct.
// Has no dependencies; the interfaces and the top level depend on it.
`default_nettype none

package shfr_pkg;

  // Header bytes and message type codes.
  localparam logic [7:0] HDR_SYNC = 8'hAA;
  localparam logic [7:0] HDR_MARK = 8'hFF;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] TYPE_GET = 8'h50;
  localparam logic [7:0] TYPE_SET = 8'h51;

  // Frame position counter: header 0..3, type 4, length 5, payload from 6.
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_SYNC0   = 9'd0;
  localparam logic [POS_W-1:0] POS_SYNC1   = 9'd1;
  localparam logic [POS_W-1:0] POS_MARK    = 9'd2;
  localparam logic [POS_W-1:0] POS_ZERO    = 9'd3;
  localparam logic [POS_W-1:0] POS_TYPE    = 9'd4;
  localparam logic [POS_W-1:0] POS_LENGTH  = 9'd5;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd6;

  // Command decoded from a good frame.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_GET  = 2'd1,
    CMD_SET  = 2'd2
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic        accepted;
    logic        frame_good;
    cmd_t        command;
    logic [7:0]  message_type;
    logic [31:0] set_value;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/shfr_if.sv @@
// Valid/ready channel interfaces for the sync-header frame receiver.
// shfr_in_if carries received bytes, shfr_out_if carries result items.
// Depends on shfr_pkg for the command type.
`default_nettype none

interface shfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfr_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               frame_good;
  shfr_pkg::cmd_t     command;
  logic [7:0]         message_type;
  logic [31:0]        set_value;

  modport source (output valid, output accepted, output frame_good, output command,
                  output message_type, output set_value, input ready);
  modport sink   (input valid, input accepted, input frame_good, input command,
                  input message_type, input set_value, output ready);
endinterface

`default_nettype wire

@@ rtl/sync_header_frame_receiver_unit.sv @@
// Top level of the sync-header frame receiver.
// Depends on shfr_pkg and on the channel interfaces in shfr_if.sv.
`default_nettype none

// Parses a byte stream into frames AA AA FF 00, type, length, payload, check byte,
// where the check byte is the XOR of type, length and payload. Every byte taken on
// in_ch gives exactly one result item on out_ch. One byte is taken per clock cycle
// while out_ch is not stalled: the frame position counter and running XOR are
// updated in the cycle a byte is accepted, and the result sits in an output
// register that refills in the same cycle it is drained. A header mismatch
// returns to the first header byte without rechecking the offending byte. A
// good frame of type 0x50 reports a volume get; type 0x51 reports a volume set
// with the first four payload bytes, little-endian, as the value word.
module sync_header_frame_receiver_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  shfr_in_if.sink    in_ch,
  shfr_out_if.source out_ch
);
  import shfr_pkg::*;

  // Frame state.
  logic [POS_W-1:0] position_r, position_nxt;
  logic [7:0]       kept_type_r, kept_type_nxt;
  logic [7:0]       kept_length_r, kept_length_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;
  logic [31:0]      value_word_r, value_word_nxt;

  // Output register.
  logic             out_valid_r;
  result_t          result_r, result_nxt;

  logic             take;
  logic [POS_W-1:0] check_pos;
  logic [POS_W-1:0] payload_idx;
  logic [7:0]       b;

  // A new byte is taken whenever the output register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign check_pos   = POS_PAYLOAD + {1'b0, kept_length_r};
  assign payload_idx = position_r - POS_PAYLOAD;

  // Per-byte frame parsing.
  always_comb begin
    position_nxt    = POS_SYNC0;
    kept_type_nxt   = kept_type_r;
    kept_length_nxt = kept_length_r;
    running_xor_nxt = running_xor_r;
    value_word_nxt  = value_word_r;
    result_nxt      = '0;
    if (position_r == POS_SYNC0 || position_r == POS_SYNC1) begin
      if (b == HDR_SYNC) begin
        result_nxt.accepted = 1'b1;
        position_nxt        = position_r + 9'd1;
      end
    end else if (position_r == POS_MARK) begin
      if (b == HDR_MARK) begin
        result_nxt.accepted = 1'b1;
        position_nxt        = POS_ZERO;
      end
    end else if (position_r == POS_ZERO) begin
      if (b == HDR_ZERO) begin
        result_nxt.accepted = 1'b1;
        position_nxt        = POS_TYPE;
      end
    end else if (position_r == POS_TYPE) begin
      kept_type_nxt       = b;
      running_xor_nxt     = b;
      result_nxt.accepted = 1'b1;
      position_nxt        = POS_LENGTH;
    end else if (position_r == POS_LENGTH) begin
      kept_length_nxt     = b;
      running_xor_nxt     = running_xor_r ^ b;
      result_nxt.accepted = 1'b1;
      position_nxt        = POS_PAYLOAD;
    end else if (position_r < check_pos) begin
      // Payload byte: the first four fill the value word, lowest byte first.
      if (payload_idx < 9'd4) begin
        value_word_nxt[payload_idx[1:0]*8 +: 8] = b;
      end
      running_xor_nxt     = running_xor_r ^ b;
      result_nxt.accepted = 1'b1;
      position_nxt        = position_r + 9'd1;
    end else if (position_r == check_pos) begin
      // Check byte: a match completes the frame and decodes its type.
      if (running_xor_r == b) begin
        result_nxt.accepted   = 1'b1;
        result_nxt.frame_good = 1'b1;
        if (kept_type_r == TYPE_GET) begin
          result_nxt.command = CMD_GET;
        end else if (kept_type_r == TYPE_SET) begin
          result_nxt.command   = CMD_SET;
          result_nxt.set_value = value_word_r;
        end
      end
    end
    result_nxt.message_type = kept_type_nxt;
  end

  // State registers, updated once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r    <= POS_SYNC0;
      kept_type_r   <= '0;
      kept_length_r <= '0;
      running_xor_r <= '0;
      value_word_r  <= '0;
    end else if (take) begin
      position_r    <= position_nxt;
      kept_type_r   <= kept_type_nxt;
      kept_length_r <= kept_length_nxt;
      running_xor_r <= running_xor_nxt;
      value_word_r  <= value_word_nxt;
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = result_r.accepted;
  assign out_ch.frame_good   = result_r.frame_good;
  assign out_ch.command      = result_r.command;
  assign out_ch.message_type = result_r.message_type;
  assign out_ch.set_value    = result_r.set_value;

endmodule

`default_nettype wire
